FILE: sv/kcl_pkg.sv
// kcl_pkg: types, codes and helpers for the keypad code lock
// used by the channel interfaces, kcl_fsm and keypad_code_lock_core
package kcl_pkg;

  localparam int KEY_W       = 4;
  localparam int CODE_W      = 20;
  localparam int CODE_DIGITS = 5;
  localparam int FAIL_W      = 4;
  localparam int CNT_W       = 3;
  localparam int PHASE_W     = 2;
  localparam int EV_W        = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;

  localparam int CODE_LEN_DEF = 5;

  localparam logic [CODE_W-1:0] USER_CODE_RST = 20'd463427;
  localparam logic [CODE_W-1:0] PASS_CODE_RST = 20'd213527;
  localparam logic [FAIL_W-1:0] MAX_FAIL_RST  = 4'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_USER_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FAIL  = 2'd2;

  // phase codes as seen on the result channel
  localparam logic [PHASE_W-1:0] PH_USER  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_PASS  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_GRANT = 2'd2;
  localparam logic [PHASE_W-1:0] PH_LOCK  = 2'd3;

  typedef enum logic [EV_W-1:0] {
    EV_DIGIT    = 3'd0,
    EV_USER_OK  = 3'd1,
    EV_USER_BAD = 3'd2,
    EV_GRANTED  = 3'd3,
    EV_WRONG    = 3'd4,
    EV_LOCKED   = 3'd5,
    EV_REPEAT   = 3'd6,
    EV_IGNORED  = 3'd7
  } ev_t;

  typedef enum logic [3:0] {
    ST_USER  = 4'b0001,
    ST_PASS  = 4'b0010,
    ST_GRANT = 4'b0100,
    ST_LOCK  = 4'b1000
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   echo_key;
    logic               echo_valid;
    ev_t                event_res;
    logic [PHASE_W-1:0] phase;
    logic [FAIL_W-1:0]  failures;
  } res_t;

  // expected digit at a position, zero beyond the stored digits
  function automatic logic [KEY_W-1:0] code_digit(input logic [CODE_W-1:0] code,
                                                  input logic [CNT_W-1:0] pos);
    logic [31:0] ext;
    ext = {12'd0, code};
    if (pos < CNT_W'(CODE_DIGITS)) begin
      return ext[{pos, 2'b00} +: KEY_W];
    end
    return '0;
  endfunction

endpackage

FILE: sv/kcl_in_if.sv
// kcl_in_if: key press channel, valid/ready with one key per transfer
// depends on kcl_pkg
interface kcl_in_if;
  logic                      valid;
  logic                      ready;
  logic [kcl_pkg::KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

FILE: sv/kcl_out_if.sv
// kcl_out_if: result channel, valid/ready with one result per transfer
// depends on kcl_pkg
interface kcl_out_if;
  logic                        valid;
  logic                        ready;
  logic [kcl_pkg::KEY_W-1:0]   echo_key;
  logic                        echo_valid;
  logic [kcl_pkg::EV_W-1:0]    event_res;
  logic [kcl_pkg::PHASE_W-1:0] phase;
  logic [kcl_pkg::FAIL_W-1:0]  failures;

  modport source (output valid, output echo_key, output echo_valid, output event_res,
                  output phase, output failures, input ready);
  modport sink   (input valid, input echo_key, input echo_valid, input event_res,
                  input phase, input failures, output ready);
endinterface

FILE: sv/kcl_fsm.sv
// kcl_fsm: login state machine, configuration registers and per-press result
// depends on kcl_pkg
module kcl_fsm #(
  parameter int CODE_LEN = kcl_pkg::CODE_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            step_en,
  input  logic [kcl_pkg::KEY_W-1:0]       key,
  output kcl_pkg::res_t                   res
);

  localparam logic [kcl_pkg::CNT_W:0] LEN_W = (kcl_pkg::CNT_W + 1)'(CODE_LEN);

  logic [kcl_pkg::CODE_W-1:0] user_code_r;
  logic [kcl_pkg::CODE_W-1:0] pass_code_r;
  logic [kcl_pkg::FAIL_W-1:0] max_fail_r;

  kcl_pkg::state_t            state_r, state_nxt;
  logic [kcl_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       mismatch_r, mismatch_nxt;
  logic [kcl_pkg::FAIL_W-1:0] fail_r, fail_nxt;

  logic                       in_entry;
  logic                       last;
  logic                       bad;
  logic [kcl_pkg::CODE_W-1:0] code;
  logic [kcl_pkg::FAIL_W-1:0] fail_inc;
  kcl_pkg::ev_t               ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_code_r <= kcl_pkg::USER_CODE_RST;
      pass_code_r <= kcl_pkg::PASS_CODE_RST;
      max_fail_r  <= kcl_pkg::MAX_FAIL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        kcl_pkg::REG_USER_CODE: user_code_r <= cfg_wdata[kcl_pkg::CODE_W-1:0];
        kcl_pkg::REG_PASS_CODE: pass_code_r <= cfg_wdata[kcl_pkg::CODE_W-1:0];
        kcl_pkg::REG_MAX_FAIL:  max_fail_r  <= cfg_wdata[kcl_pkg::FAIL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_entry = (state_r == kcl_pkg::ST_USER) || (state_r == kcl_pkg::ST_PASS);
  assign code     = (state_r == kcl_pkg::ST_USER) ? user_code_r : pass_code_r;
  assign bad      = mismatch_r || (key != kcl_pkg::code_digit(code, cnt_r));
  assign last     = ({1'b0, cnt_r} + 1'b1) >= LEN_W;
  assign fail_inc = (fail_r == '1) ? fail_r : fail_r + 1'b1;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    mismatch_nxt = mismatch_r;
    fail_nxt     = fail_r;
    ev           = kcl_pkg::EV_IGNORED;
    unique case (state_r)
      kcl_pkg::ST_USER, kcl_pkg::ST_PASS: begin
        if (last) begin
          cnt_nxt      = '0;
          mismatch_nxt = 1'b0;
          if (state_r == kcl_pkg::ST_USER) begin
            if (bad) begin
              ev = kcl_pkg::EV_USER_BAD;
            end else begin
              ev        = kcl_pkg::EV_USER_OK;
              state_nxt = kcl_pkg::ST_PASS;
            end
          end else if (!bad) begin
            ev        = kcl_pkg::EV_GRANTED;
            state_nxt = kcl_pkg::ST_GRANT;
          end else begin
            fail_nxt = fail_inc;
            if (fail_inc >= max_fail_r) begin
              ev        = kcl_pkg::EV_LOCKED;
              state_nxt = kcl_pkg::ST_LOCK;
            end else begin
              ev = kcl_pkg::EV_WRONG;
            end
          end
        end else begin
          ev           = kcl_pkg::EV_DIGIT;
          cnt_nxt      = cnt_r + 1'b1;
          mismatch_nxt = bad;
        end
      end
      kcl_pkg::ST_GRANT: ev = kcl_pkg::EV_REPEAT;
      kcl_pkg::ST_LOCK:  ev = kcl_pkg::EV_IGNORED;
      default:           ev = kcl_pkg::EV_IGNORED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= kcl_pkg::ST_USER;
      cnt_r      <= '0;
      mismatch_r <= 1'b0;
      fail_r     <= '0;
    end else if (step_en) begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      mismatch_r <= mismatch_nxt;
      fail_r     <= fail_nxt;
    end
  end

  always_comb begin
    res.echo_key   = in_entry ? key : '0;
    res.echo_valid = in_entry;
    res.event_res  = ev;
    res.failures   = fail_nxt;
    unique case (state_nxt)
      kcl_pkg::ST_USER:  res.phase = kcl_pkg::PH_USER;
      kcl_pkg::ST_PASS:  res.phase = kcl_pkg::PH_PASS;
      kcl_pkg::ST_GRANT: res.phase = kcl_pkg::PH_GRANT;
      kcl_pkg::ST_LOCK:  res.phase = kcl_pkg::PH_LOCK;
      default:           res.phase = kcl_pkg::PH_LOCK;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_lock_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kcl_pkg::ST_LOCK |=> state_r == kcl_pkg::ST_LOCK)
    else $error("lock left without reset");

  a_fail_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> fail_r >= $past(fail_r))
    else $error("failure count decreased");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cnt_r} < LEN_W)
    else $error("digit count past code length");

  a_entry_end: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && in_entry && last |=> cnt_r == '0 && !mismatch_r)
    else $error("entry state not cleared at end of code");
`endif

endmodule

FILE: sv/keypad_code_lock_core.sv
// keypad_code_lock_core: two-step keypad code lock with failure lockout
// pipeline: input register key_r, then result register res_r; the result is valid
//   in the cycle after its key advances out of the input register
// throughput: one press per cycle while out_ch.ready; result register frees as it is taken
// reset: synchronous active-low rst_n returns to user entry with zero failures and
//   restores the default codes and failure limit; depends on kcl_pkg, kcl_fsm, kcl_*_if
module keypad_code_lock_core #(
  parameter int CODE_LEN = kcl_pkg::CODE_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  kcl_in_if.sink                          in_ch,
  kcl_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic                      in_vld_r;
  logic [kcl_pkg::KEY_W-1:0] key_r;
  logic                      out_vld_r;
  kcl_pkg::res_t             res_r;
  kcl_pkg::res_t             res;
  logic                      adv;

  assign adv         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      key_r <= in_ch.key;
    end
  end

  kcl_fsm #(
    .CODE_LEN (CODE_LEN)
  ) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .step_en   (adv),
    .key       (key_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.echo_key   = res_r.echo_key;
  assign out_ch.echo_valid = res_r.echo_valid;
  assign out_ch.event_res  = res_r.event_res;
  assign out_ch.phase      = res_r.phase;
  assign out_ch.failures   = res_r.failures;

endmodule
